### src/sfr_pkg.sv
// sfr_pkg: shared types and constants of the stream find-and-replace unit
// used by the interfaces, the config registers, the sequencer and the top level
// depends on nothing
`default_nettype none

package sfr_pkg;

	localparam int MAX_PATTERN     = 8;
	localparam int MAX_REPLACEMENT = 8;
	localparam int CHAR_W          = 8;
	localparam int CNT_W           = 4;
	localparam int CFG_IDX_W       = 3;
	localparam int CFG_DATA_W      = 64;

	// register indexes of the config port
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_BYTES  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_LENGTH = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_REPLACE_EVERY      = 3'd4;

	// effective configuration seen by the sequencer
	typedef struct packed {
		logic [MAX_PATTERN-1:0][CHAR_W-1:0]     pat_bytes;
		logic [CNT_W-1:0]                       pat_len;
		logic [MAX_REPLACEMENT-1:0][CHAR_W-1:0] repl_bytes;
		logic [CNT_W-1:0]                       repl_len;
		logic                                   replace_every;
	} cfg_t;

	// one result word handed from the sequencer to the output register
	typedef struct packed {
		logic              push;
		logic [CHAR_W-1:0] ch;
		logic              char_valid;
		logic              run_last;
		logic              string_done;
	} push_t;

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_PRE    = 7'b0000010,
		ST_CHECK  = 7'b0000100,
		ST_REPL   = 7'b0001000,
		ST_POST   = 7'b0010000,
		ST_FLUSH  = 7'b0100000,
		ST_FINISH = 7'b1000000
	} seq_state_t;

endpackage

`default_nettype wire

### src/sfr_in_if.sv
// sfr_in_if: input channel of the find-and-replace unit, one string byte per word
// depends on sfr_pkg
`default_nettype none

interface sfr_in_if;
	logic                      valid;
	logic                      ready;
	logic [sfr_pkg::CHAR_W-1:0] char_in;
	logic                      end_of_string;

	modport source(output valid, char_in, end_of_string, input ready);
	modport sink(input valid, char_in, end_of_string, output ready);
endinterface

`default_nettype wire

### src/sfr_out_if.sv
// sfr_out_if: output channel of the find-and-replace unit, one edited byte per word
// depends on sfr_pkg
`default_nettype none

interface sfr_out_if;
	logic                      valid;
	logic                      ready;
	logic [sfr_pkg::CHAR_W-1:0] char_out;
	logic                      char_valid;
	logic                      run_last;
	logic                      string_done;

	modport source(output valid, char_out, char_valid, run_last, string_done, input ready);
	modport sink(input valid, char_out, char_valid, run_last, string_done, output ready);
endinterface

`default_nettype wire

### src/sfr_cfg_if.sv
// sfr_cfg_if: register write channel of the find-and-replace unit
// depends on sfr_pkg
`default_nettype none

interface sfr_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [sfr_pkg::CFG_IDX_W-1:0]  index;
	logic [sfr_pkg::CFG_DATA_W-1:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

`default_nettype wire

### src/stream_find_and_replace_unit.sv
// stream_find_and_replace_unit: streaming find and replace on a byte string
// Channels: in_ch takes one string byte per word with end_of_string on the last
// byte; out_ch gives the edited string one byte per word, run_last on the last
// word caused by an input byte and string_done on the last word of the string;
// cfg_ch writes pattern, lengths, replacement and mode; the user must write
// them only while idle, as the block itself does not enforce it.
// Each input byte is handled by a sequencer that shares one prefix compare
// unit; in_ch.ready is high only while the sequencer is idle.
// An accepted byte passes the states PRE, CHECK, REPL or POST, FLUSH and
// FINISH, releasing held bytes in PRE, POST and at end of string FLUSH, and
// producing replacement bytes in REPL; in first-only mode after a replacement
// it goes from PRE straight to FLUSH. A new byte is accepted only once the
// sequencer is idle again. The sequencer emits at most one word per cycle.
// An input byte that produces no output (held as a possible match) gives no word;
// at end of string with nothing to send an empty word with char_valid low is sent.
// Reset clears the held count, the replaced flag and the output valid flag and
// sets the registers to pattern length 1, replacement length 0, replace every.
// While out_ch is stalled the output register holds its word and the sequencer
// waits, though it can still accept a byte while idle; config writes are taken every cycle.
// depends on sfr_pkg, the sfr_*_if interfaces, sfr_cfg_regs and sfr_seq
`default_nettype none

module stream_find_and_replace_unit (
	input  wire logic   clk,
	input  wire logic   arst_n,
	sfr_in_if.sink      in_ch,
	sfr_out_if.source   out_ch,
	sfr_cfg_if.sink     cfg_ch
);

	sfr_pkg::cfg_t               cfg;
	sfr_pkg::push_t              push;
	logic                        out_go;
	logic                        out_valid_q;
	logic [sfr_pkg::CHAR_W-1:0]  char_out_q;
	logic                        char_valid_q;
	logic                        run_last_q;
	logic                        string_done_q;

	assign cfg_ch.ready = 1'b1;

	sfr_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_ch.valid),
		.wr_index (cfg_ch.index),
		.wr_data  (cfg_ch.data),
		.cfg      (cfg)
	);

	sfr_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.in_valid (in_ch.valid),
		.in_char  (in_ch.char_in),
		.in_eos   (in_ch.end_of_string),
		.in_ready (in_ch.ready),
		.out_go   (out_go),
		.push     (push)
	);

	// output register, free when empty or being taken
	assign out_go = !out_valid_q || out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push.push) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push.push) begin
			char_out_q    <= push.ch;
			char_valid_q  <= push.char_valid;
			run_last_q    <= push.run_last;
			string_done_q <= push.string_done;
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.char_out    = char_out_q;
	assign out_ch.char_valid  = char_valid_q;
	assign out_ch.run_last    = run_last_q;
	assign out_ch.string_done = string_done_q;

endmodule

`default_nettype wire

### src/sfr_cfg_regs.sv
// sfr_cfg_regs: configuration registers and effective length clamping
// depends on sfr_pkg
`default_nettype none

module sfr_cfg_regs (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           wr_en,
	input  wire logic [sfr_pkg::CFG_IDX_W-1:0]  wr_index,
	input  wire logic [sfr_pkg::CFG_DATA_W-1:0] wr_data,
	output sfr_pkg::cfg_t                       cfg
);

	logic [sfr_pkg::CFG_DATA_W-1:0] pat_bytes_q;
	logic [sfr_pkg::CNT_W-1:0]      pat_len_q;
	logic [sfr_pkg::CFG_DATA_W-1:0] repl_bytes_q;
	logic [sfr_pkg::CNT_W-1:0]      repl_len_q;
	logic                           replace_every_q;

	// register writes, unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_bytes_q     <= '0;
			pat_len_q       <= sfr_pkg::CNT_W'(1);
			repl_bytes_q    <= '0;
			repl_len_q      <= '0;
			replace_every_q <= 1'b1;
		end else if (wr_en) begin
			unique case (wr_index)
				sfr_pkg::REG_PATTERN_BYTES:      pat_bytes_q     <= wr_data;
				sfr_pkg::REG_PATTERN_LENGTH:     pat_len_q       <= wr_data[sfr_pkg::CNT_W-1:0];
				sfr_pkg::REG_REPLACEMENT_BYTES:  repl_bytes_q    <= wr_data;
				sfr_pkg::REG_REPLACEMENT_LENGTH: repl_len_q      <= wr_data[sfr_pkg::CNT_W-1:0];
				sfr_pkg::REG_REPLACE_EVERY:      replace_every_q <= wr_data[0];
				default: ;
			endcase
		end
	end

	// clamp lengths: pattern 1..8, replacement 0..8
	always_comb begin
		cfg.pat_bytes     = pat_bytes_q;
		cfg.repl_bytes    = repl_bytes_q;
		cfg.replace_every = replace_every_q;
		if (pat_len_q == '0) begin
			cfg.pat_len = sfr_pkg::CNT_W'(1);
		end else if (pat_len_q > sfr_pkg::CNT_W'(sfr_pkg::MAX_PATTERN)) begin
			cfg.pat_len = sfr_pkg::CNT_W'(sfr_pkg::MAX_PATTERN);
		end else begin
			cfg.pat_len = pat_len_q;
		end
		if (repl_len_q > sfr_pkg::CNT_W'(sfr_pkg::MAX_REPLACEMENT)) begin
			cfg.repl_len = sfr_pkg::CNT_W'(sfr_pkg::MAX_REPLACEMENT);
		end else begin
			cfg.repl_len = repl_len_q;
		end
	end

endmodule

`default_nettype wire

### src/sfr_prefix_cmp.sv
// sfr_prefix_cmp: shared compare unit, checks the first n held bytes against the pattern
// depends on sfr_pkg
`default_nettype none

module sfr_prefix_cmp (
	input  wire logic [sfr_pkg::MAX_PATTERN-1:0][sfr_pkg::CHAR_W-1:0] held,
	input  wire logic [sfr_pkg::MAX_PATTERN-1:0][sfr_pkg::CHAR_W-1:0] pattern,
	input  wire logic [sfr_pkg::CNT_W-1:0]                            n,
	output logic                                                      is_prefix
);

	logic [sfr_pkg::MAX_PATTERN-1:0] hit;

	// positions at or past n always agree
	always_comb begin
		for (int i = 0; i < sfr_pkg::MAX_PATTERN; i++) begin
			hit[i] = (sfr_pkg::CNT_W'(i) >= n) || (held[i] == pattern[i]);
		end
		is_prefix = &hit;
	end

endmodule

`default_nettype wire

### src/sfr_seq.sv
// sfr_seq: held-byte sequencer, one release or replacement byte per cycle unless stalled
// depends on sfr_pkg and sfr_prefix_cmp
`default_nettype none

module sfr_seq (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire sfr_pkg::cfg_t               cfg,
	input  wire logic                        in_valid,
	input  wire logic [sfr_pkg::CHAR_W-1:0]  in_char,
	input  wire logic                        in_eos,
	output logic                             in_ready,
	input  wire logic                        out_go,
	output sfr_pkg::push_t                   push
);

	sfr_pkg::seq_state_t                                    state_q, state_d;
	logic [sfr_pkg::MAX_PATTERN-1:0][sfr_pkg::CHAR_W-1:0]   held_q;
	logic [sfr_pkg::CNT_W-1:0]                              cnt_q;
	logic [sfr_pkg::CNT_W-1:0]                              idx_q;
	logic                                                   replaced_q;
	logic [sfr_pkg::CHAR_W-1:0]                             char_q;
	logic                                                   eos_q;
	logic                                                   pend_v_q;
	logic [sfr_pkg::CHAR_W-1:0]                             pend_c_q;

	logic                        pfx;
	logic                        bypass;
	logic                        rel_match;
	logic                        rel_pre;
	logic                        full_match;
	logic                        step;
	logic                        prod;
	logic                        shift;
	logic                        append;
	logic [sfr_pkg::CHAR_W-1:0]  prod_byte;

	sfr_prefix_cmp u_cmp (
		.held      (held_q),
		.pattern   (cfg.pat_bytes),
		.n         (cnt_q),
		.is_prefix (pfx)
	);

	// release and match decisions
	assign bypass     = replaced_q && !cfg.replace_every;
	assign rel_match  = (cnt_q != '0) && !((cnt_q < cfg.pat_len) && pfx);
	assign rel_pre    = bypass ? (cnt_q != '0) : rel_match;
	assign full_match = (cnt_q == cfg.pat_len) && pfx;
	assign step       = (state_q == sfr_pkg::ST_IDLE) || out_go;
	assign in_ready   = (state_q == sfr_pkg::ST_IDLE);

	// next state and the byte produced this cycle
	always_comb begin
		state_d   = state_q;
		prod      = 1'b0;
		shift     = 1'b0;
		append    = 1'b0;
		prod_byte = held_q[0];
		unique case (state_q)
			sfr_pkg::ST_IDLE: begin
				if (in_valid) state_d = sfr_pkg::ST_PRE;
			end
			sfr_pkg::ST_PRE: begin
				if (rel_pre) begin
					prod  = 1'b1;
					shift = 1'b1;
				end else if (bypass) begin
					prod      = 1'b1;
					prod_byte = char_q;
					state_d   = sfr_pkg::ST_FLUSH;
				end else begin
					append  = 1'b1;
					state_d = sfr_pkg::ST_CHECK;
				end
			end
			sfr_pkg::ST_CHECK: begin
				state_d = full_match ? sfr_pkg::ST_REPL : sfr_pkg::ST_POST;
			end
			sfr_pkg::ST_REPL: begin
				if (idx_q < cfg.repl_len) begin
					prod      = 1'b1;
					prod_byte = cfg.repl_bytes[idx_q[2:0]];
				end else begin
					state_d = sfr_pkg::ST_FLUSH;
				end
			end
			sfr_pkg::ST_POST: begin
				if (rel_match) begin
					prod  = 1'b1;
					shift = 1'b1;
				end else begin
					state_d = sfr_pkg::ST_FLUSH;
				end
			end
			sfr_pkg::ST_FLUSH: begin
				if (eos_q && (cnt_q != '0)) begin
					prod  = 1'b1;
					shift = 1'b1;
				end else begin
					state_d = sfr_pkg::ST_FINISH;
				end
			end
			sfr_pkg::ST_FINISH: begin
				state_d = sfr_pkg::ST_IDLE;
			end
			default: state_d = sfr_pkg::ST_IDLE;
		endcase
	end

	// a produced byte waits in the pending slot so the last one can be flagged
	always_comb begin
		push.push        = 1'b0;
		push.ch          = pend_c_q;
		push.char_valid  = 1'b1;
		push.run_last    = 1'b0;
		push.string_done = 1'b0;
		if (state_q == sfr_pkg::ST_FINISH) begin
			push.push        = out_go && (pend_v_q || eos_q);
			push.ch          = pend_v_q ? pend_c_q : '0;
			push.char_valid  = pend_v_q;
			push.run_last    = 1'b1;
			push.string_done = eos_q;
		end else begin
			push.push = out_go && prod && pend_v_q;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= sfr_pkg::ST_IDLE;
			cnt_q      <= '0;
			idx_q      <= '0;
			replaced_q <= 1'b0;
			pend_v_q   <= 1'b0;
		end else if (step) begin
			state_q <= state_d;
			if (shift) cnt_q <= cnt_q - sfr_pkg::CNT_W'(1);
			if (append) cnt_q <= cnt_q + sfr_pkg::CNT_W'(1);
			if (state_q == sfr_pkg::ST_CHECK) begin
				idx_q <= '0;
				if (full_match) begin
					cnt_q      <= '0;
					replaced_q <= 1'b1;
				end
			end
			if ((state_q == sfr_pkg::ST_REPL) && prod) idx_q <= idx_q + sfr_pkg::CNT_W'(1);
			if ((state_q == sfr_pkg::ST_FLUSH) && !prod && eos_q) begin
				cnt_q      <= '0;
				replaced_q <= 1'b0;
			end
			if (prod) pend_v_q <= 1'b1;
			if (state_q == sfr_pkg::ST_FINISH) pend_v_q <= 1'b0;
		end
	end

	// held bytes and captured input word
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			char_q <= in_char;
			eos_q  <= in_eos;
		end
		if (step) begin
			if (prod) pend_c_q <= prod_byte;
			if (shift) begin
				for (int i = 0; i < sfr_pkg::MAX_PATTERN - 1; i++) begin
					held_q[i] <= held_q[i+1];
				end
			end
			if (append) held_q[cnt_q[2:0]] <= char_q;
		end
	end

endmodule

`default_nettype wire
